[src/haf_pkg.sv]
package haf_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int MAG_W     = COORD_W + 1;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int D2_W      = 66;
    localparam int GAIN_W    = 31;
    localparam int RAD_W     = 24;
    localparam int RSQ_W     = 2 * RAD_W;
    localparam int MAXF_W    = 31;
    localparam int WARM_W    = 16;
    localparam int TICK_W    = WARM_W + 1;
    localparam int NUM_W     = GAIN_W + MAG_W;
    localparam int QUO_W     = 32;
    localparam int SHIFT_INV = 16;
    localparam int SHIFT_SPR = 14;
    localparam int FULL_W    = NUM_W + SHIFT_INV;
    localparam int HI_W      = FULL_W - QUO_W;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int AXES      = 3;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(2621440);
    localparam logic [RAD_W-1:0]  RAD_RST  = RAD_W'(327680);
    localparam logic [MAXF_W-1:0] MAXF_RST = MAXF_W'(57672);
    localparam logic [WARM_W-1:0] WARM_RST = WARM_W'(2000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_RADIUS = 2'd1,
        CFG_MAXF   = 2'd2,
        CFG_WARM   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_WAIT, S_MXX, S_MYY, S_MZZ, S_RR, S_GX, S_GY, S_GZ,
        S_NUMZ, S_DIVINIT, S_DIVSTEP, S_FINISH
    } t_step;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_MXX, MUL_MYY, MUL_MZZ, MUL_RR, MUL_GX, MUL_GY, MUL_GZ
    } t_mul_op;

    typedef enum logic [2:0] {
        DST_NONE, DST_D2_LOAD, DST_D2_ADD, DST_RSQ, DST_NUM0, DST_NUM1, DST_NUM2
    } t_dst;

    typedef enum logic [1:0] {
        C_NONE, C_NO_INPUT, C_COUNT, C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_mul_op mul_op;
        t_dst    dst;
        logic    sel_den;
        logic    div_init;
        logic    div_step;
        logic    take;
        logic    out_write;
        t_cond   cond;
        t_step   jmp;
        t_step   nxt;
    } t_uword;

    typedef struct packed {
        t_mul_op mul_op;
        t_dst    dst;
        logic    sel_den;
        logic    div_init;
        logic    div_step;
        logic    take;
        logic    out_load;
    } t_ctl;

    typedef struct packed {
        logic [MAXF_W-1:0] mag;
        logic              clip;
    } t_lane_res;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] force_v;
        logic                         spring;
        logic                         limited;
        logic                         enabled;
    } t_result;

    // build one control word
    function automatic t_uword uw(t_mul_op m, t_dst d, logic sel, logic init, logic stp,
                                  logic tk, logic ow, t_cond c, t_step j, t_step n);
        t_uword w;
        w.mul_op    = m;
        w.dst       = d;
        w.sel_den   = sel;
        w.div_init  = init;
        w.div_step  = stp;
        w.take      = tk;
        w.out_write = ow;
        w.cond      = c;
        w.jmp       = j;
        w.nxt       = n;
        return w;
    endfunction

    // control store
    function automatic t_uword uc_rom(t_step s);
        t_uword w;
        unique case (s)
            S_WAIT:    w = uw(MUL_NONE, DST_NONE,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                              C_NO_INPUT, S_WAIT, S_MXX);
            S_MXX:     w = uw(MUL_MXX,  DST_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_MYY);
            S_MYY:     w = uw(MUL_MYY,  DST_D2_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_MZZ);
            S_MZZ:     w = uw(MUL_MZZ,  DST_D2_ADD,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_RR);
            S_RR:      w = uw(MUL_RR,   DST_D2_ADD,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_GX);
            S_GX:      w = uw(MUL_GX,   DST_RSQ,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_GY);
            S_GY:      w = uw(MUL_GY,   DST_NUM0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_GZ);
            S_GZ:      w = uw(MUL_GZ,   DST_NUM1,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_NUMZ);
            S_NUMZ:    w = uw(MUL_NONE, DST_NUM2,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_DIVINIT);
            S_DIVINIT: w = uw(MUL_NONE, DST_NONE,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_DIVSTEP);
            S_DIVSTEP: w = uw(MUL_NONE, DST_NONE,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                              C_COUNT, S_DIVSTEP, S_FINISH);
            S_FINISH:  w = uw(MUL_NONE, DST_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                              C_OUT_BUSY, S_FINISH, S_WAIT);
            default:   w = uw(MUL_NONE, DST_NONE,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                              C_NONE, S_WAIT, S_WAIT);
        endcase
        return w;
    endfunction

endpackage

[src/haf_sequencer.sv]
module haf_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_busy,
    output haf_pkg::t_ctl   o_ctl
);

    localparam logic [haf_pkg::CNT_W-1:0] CNT_LAST = haf_pkg::CNT_W'(haf_pkg::QUO_W - 1);

    haf_pkg::t_step             r_pc, n_pc;
    logic [haf_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    haf_pkg::t_uword            w;
    logic                       hit;

    // fetch and branch
    always_comb begin
        w = haf_pkg::uc_rom(r_pc);
        unique case (w.cond)
            haf_pkg::C_NONE:     hit = 1'b0;
            haf_pkg::C_NO_INPUT: hit = !i_in_valid;
            haf_pkg::C_COUNT:    hit = (r_cnt != CNT_LAST);
            haf_pkg::C_OUT_BUSY: hit = i_out_busy;
            default:             hit = 1'b0;
        endcase
        n_pc  = hit ? w.jmp : w.nxt;
        n_cnt = r_cnt;
        if (w.div_step) begin
            n_cnt = (r_cnt == CNT_LAST) ? '0 : r_cnt + 1'b1;
        end
        o_ctl.mul_op   = w.mul_op;
        o_ctl.dst      = w.dst;
        o_ctl.sel_den  = w.sel_den;
        o_ctl.div_init = w.div_init;
        o_ctl.div_step = w.div_step;
        o_ctl.take     = w.take && i_in_valid;
        o_ctl.out_load = w.out_write && !i_out_busy;
    end

    // step counter and loop count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= haf_pkg::S_WAIT;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/haf_div_lane.sv]
module haf_div_lane (
    input  logic                         i_clk,
    input  haf_pkg::t_ctl                i_ctl,
    input  logic [haf_pkg::NUM_W-1:0]    i_num,
    input  logic                         i_spring,
    input  logic [haf_pkg::D2_W-1:0]     i_den,
    input  logic                         i_den_zero,
    input  logic [haf_pkg::MAXF_W-1:0]   i_max_force,
    output haf_pkg::t_lane_res           o_res
);

    logic [haf_pkg::D2_W-1:0]   r_rem, n_rem;
    logic [haf_pkg::QUO_W-1:0]  r_quo, n_quo;
    logic                       r_ovf, n_ovf;
    logic [haf_pkg::FULL_W-1:0] full;
    logic [haf_pkg::HI_W-1:0]   hi;
    logic [haf_pkg::D2_W:0]     trial, den_ext;
    logic                       ge;
    logic                       over;

    // one restoring step a cycle; overflow caught up front
    always_comb begin
        full    = haf_pkg::FULL_W'(i_num) << (i_spring ? haf_pkg::SHIFT_SPR : haf_pkg::SHIFT_INV);
        hi      = full[haf_pkg::FULL_W-1 -: haf_pkg::HI_W];
        den_ext = {1'b0, i_den};
        trial   = {r_rem, r_quo[haf_pkg::QUO_W-1]};
        ge      = (trial >= den_ext);
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_ovf   = r_ovf;
        if (i_ctl.div_init) begin
            n_ovf = (haf_pkg::D2_W'(hi) >= i_den);
            n_rem = haf_pkg::D2_W'(hi);
            n_quo = full[haf_pkg::QUO_W-1:0];
        end else if (i_ctl.div_step) begin
            n_rem = ge ? haf_pkg::D2_W'(trial - den_ext) : trial[haf_pkg::D2_W-1:0];
            n_quo = {r_quo[haf_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_ovf <= n_ovf;
    end

    // saturate to the limit; a zero divisor gives zero force
    always_comb begin
        over = r_ovf || (r_quo > {1'b0, i_max_force});
        if (i_den_zero) begin
            o_res.mag  = '0;
            o_res.clip = 1'b0;
        end else if (over) begin
            o_res.mag  = i_max_force;
            o_res.clip = 1'b1;
        end else begin
            o_res.mag  = r_quo[haf_pkg::MAXF_W-1:0];
            o_res.clip = 1'b0;
        end
    end

endmodule

[src/haf_datapath.sv]
module haf_datapath (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  haf_pkg::t_ctl                                 i_ctl,
    input  logic [haf_pkg::AXES-1:0][haf_pkg::COORD_W-1:0] i_proxy,
    input  logic [haf_pkg::AXES-1:0][haf_pkg::COORD_W-1:0] i_object,
    input  logic [haf_pkg::GAIN_W-1:0]                    i_gain,
    input  logic [haf_pkg::RAD_W-1:0]                     i_radius,
    input  logic [haf_pkg::MAXF_W-1:0]                    i_max_force,
    input  logic [haf_pkg::WARM_W-1:0]                    i_warmup,
    output haf_pkg::t_result                              o_result
);

    localparam int MW = haf_pkg::MAG_W;

    logic [haf_pkg::AXES-1:0][MW-1:0]              r_mag;
    logic [haf_pkg::AXES-1:0]                      r_neg;
    logic [haf_pkg::PROD_W-1:0]                    r_prod;
    logic [haf_pkg::D2_W-1:0]                      r_d2;
    logic [haf_pkg::RSQ_W-1:0]                     r_rsq;
    logic [haf_pkg::AXES-1:0][haf_pkg::NUM_W-1:0]  r_num;
    logic [haf_pkg::D2_W-1:0]                      r_den;
    logic                                          r_den_zero;
    logic                                          r_spring;
    logic [haf_pkg::TICK_W-1:0]                    r_tick;
    logic                                          r_enabled;

    logic [haf_pkg::AXES-1:0][MW-1:0]              diff;
    logic [MW-1:0]                                 mul_a, mul_b;
    logic [haf_pkg::D2_W-1:0]                      core, den_sel;
    logic                                          spring_now;
    logic [haf_pkg::TICK_W-1:0]                    tick_inc, tick_top;
    logic                                          en_now;
    haf_pkg::t_lane_res [haf_pkg::AXES-1:0]        lane;
    logic [haf_pkg::AXES-1:0]                      clip;

    // sign-extended differences; their magnitudes are taken on capture
    always_comb begin
        for (int i = 0; i < haf_pkg::AXES; i++) begin
            diff[i] = {i_object[i][haf_pkg::COORD_W-1], i_object[i]}
                    - {i_proxy[i][haf_pkg::COORD_W-1], i_proxy[i]};
        end
    end

    // warm-up count
    always_comb begin
        tick_inc = r_tick + 1'b1;
        tick_top = haf_pkg::TICK_W'(i_warmup) + 1'b1;
        en_now   = (tick_inc > haf_pkg::TICK_W'(i_warmup));
    end

    // capture an item and step the tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (i_ctl.take) begin
            r_tick <= en_now ? tick_top : tick_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_enabled <= en_now;
            for (int i = 0; i < haf_pkg::AXES; i++) begin
                r_neg[i] <= diff[i][MW-1];
                r_mag[i] <= diff[i][MW-1] ? MW'(-diff[i]) : diff[i];
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_ctl.mul_op)
            haf_pkg::MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            haf_pkg::MUL_MXX: begin
                mul_a = r_mag[0];
                mul_b = r_mag[0];
            end
            haf_pkg::MUL_MYY: begin
                mul_a = r_mag[1];
                mul_b = r_mag[1];
            end
            haf_pkg::MUL_MZZ: begin
                mul_a = r_mag[2];
                mul_b = r_mag[2];
            end
            haf_pkg::MUL_RR: begin
                mul_a = MW'(i_radius);
                mul_b = MW'(i_radius);
            end
            haf_pkg::MUL_GX: begin
                mul_a = MW'(i_gain);
                mul_b = r_mag[0];
            end
            haf_pkg::MUL_GY: begin
                mul_a = MW'(i_gain);
                mul_b = r_mag[1];
            end
            haf_pkg::MUL_GZ: begin
                mul_a = MW'(i_gain);
                mul_b = r_mag[2];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // choose the law and the divisor
    always_comb begin
        core       = haf_pkg::D2_W'({r_rsq, 2'b00});
        spring_now = (r_d2 < core);
        den_sel    = spring_now ? haf_pkg::D2_W'(r_rsq) : r_d2;
    end

    // product register and its destinations
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_ctl.dst)
            haf_pkg::DST_D2_LOAD: r_d2     <= r_prod;
            haf_pkg::DST_D2_ADD:  r_d2     <= r_d2 + r_prod;
            haf_pkg::DST_RSQ:     r_rsq    <= r_prod[haf_pkg::RSQ_W-1:0];
            haf_pkg::DST_NUM0:    r_num[0] <= r_prod[haf_pkg::NUM_W-1:0];
            haf_pkg::DST_NUM1:    r_num[1] <= r_prod[haf_pkg::NUM_W-1:0];
            haf_pkg::DST_NUM2:    r_num[2] <= r_prod[haf_pkg::NUM_W-1:0];
            default: ;
        endcase
        if (i_ctl.sel_den) begin
            r_spring   <= spring_now;
            r_den      <= den_sel;
            r_den_zero <= (den_sel == '0);
        end
    end

    // one divider lane per axis
    for (genvar g = 0; g < haf_pkg::AXES; g++) begin : g_lane
        haf_div_lane u_lane (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_num       (r_num[g]),
            .i_spring    (r_spring),
            .i_den       (r_den),
            .i_den_zero  (r_den_zero),
            .i_max_force (i_max_force),
            .o_res       (lane[g])
        );
    end

    // apply sign and the warm-up gate
    always_comb begin
        for (int i = 0; i < haf_pkg::AXES; i++) begin
            clip[i] = lane[i].clip;
            if (!r_enabled) begin
                o_result.force_v[i] = '0;
            end else if (r_neg[i]) begin
                o_result.force_v[i] = haf_pkg::COORD_W'(-{1'b0, lane[i].mag});
            end else begin
                o_result.force_v[i] = haf_pkg::COORD_W'({1'b0, lane[i].mag});
            end
        end
        o_result.spring  = r_spring;
        o_result.limited = r_enabled && (|clip);
        o_result.enabled = r_enabled;
    end

endmodule

[src/haptic_attraction_force.sv]
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_proxy_{x,y,z}, i_object_{x,y,z}
// output    out        o_out_valid / i_out_stall o_force_{x,y,z}, o_spring_region,
//                                                o_limited, o_enabled
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Between one acceptance and the next, an item passes through the accepting step, seven
// products and a write-back on the shared 33x33 multiplier, one set-up step, 32 radix-2
// division steps on all three axes at once, and one step to load the output register.
// The result waits in the output register while the next item is worked on; the
// finishing step holds until that register is free. Reset clears the step counter,
// the tick counter and the output valid flag and reloads the register defaults.
module haptic_attraction_force (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [haf_pkg::COORD_W-1:0] i_proxy_x,
    input  logic signed [haf_pkg::COORD_W-1:0] i_proxy_y,
    input  logic signed [haf_pkg::COORD_W-1:0] i_proxy_z,
    input  logic signed [haf_pkg::COORD_W-1:0] i_object_x,
    input  logic signed [haf_pkg::COORD_W-1:0] i_object_y,
    input  logic signed [haf_pkg::COORD_W-1:0] i_object_z,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [haf_pkg::COORD_W-1:0] o_force_x,
    output logic signed [haf_pkg::COORD_W-1:0] o_force_y,
    output logic signed [haf_pkg::COORD_W-1:0] o_force_z,
    output logic                              o_spring_region,
    output logic                              o_limited,
    output logic                              o_enabled,
    input  logic                              i_cfg_we,
    input  logic [haf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [haf_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [haf_pkg::GAIN_W-1:0] r_gain;
    logic [haf_pkg::RAD_W-1:0]  r_radius;
    logic [haf_pkg::MAXF_W-1:0] r_max_force;
    logic [haf_pkg::WARM_W-1:0] r_warmup;
    logic                       r_out_valid;
    haf_pkg::t_result           r_out;
    haf_pkg::t_result           result;
    haf_pkg::t_ctl              ctl;
    logic                       out_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= haf_pkg::GAIN_RST;
            r_radius    <= haf_pkg::RAD_RST;
            r_max_force <= haf_pkg::MAXF_RST;
            r_warmup    <= haf_pkg::WARM_RST;
        end else if (i_cfg_we) begin
            unique case (haf_pkg::t_cfg_idx'(i_cfg_idx))
                haf_pkg::CFG_GAIN:   r_gain      <= i_cfg_data[haf_pkg::GAIN_W-1:0];
                haf_pkg::CFG_RADIUS: r_radius    <= i_cfg_data[haf_pkg::RAD_W-1:0];
                haf_pkg::CFG_MAXF:   r_max_force <= i_cfg_data[haf_pkg::MAXF_W-1:0];
                haf_pkg::CFG_WARM:   r_warmup    <= i_cfg_data[haf_pkg::WARM_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_busy   = r_out_valid && i_out_stall;
    assign o_in_stall = !ctl.take;

    haf_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (out_busy),
        .o_ctl      (ctl)
    );

    haf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_proxy     ({i_proxy_z, i_proxy_y, i_proxy_x}),
        .i_object    ({i_object_z, i_object_y, i_object_x}),
        .i_gain      (r_gain),
        .i_radius    (r_radius),
        .i_max_force (r_max_force),
        .i_warmup    (r_warmup),
        .o_result    (result)
    );

    // output register: load when free, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_force_x       = r_out.force_v[0];
    assign o_force_y       = r_out.force_v[1];
    assign o_force_z       = r_out.force_v[2];
    assign o_spring_region = r_out.spring;
    assign o_limited       = r_out.limited;
    assign o_enabled       = r_out.enabled;

    // checks
    a_no_take_while_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.take |-> !ctl.out_load)
        else $error("input transfer during output load");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |=> o_out_valid)
        else $error("output load did not raise valid");

    a_limited_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_limited) |-> o_enabled)
        else $error("limited flagged during warm-up");

    a_zero_in_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_enabled) |-> (o_force_x == '0 && o_force_y == '0
                                          && o_force_z == '0))
        else $error("force driven during warm-up");

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import haf_pkg::*;

    // generous cycle budget for the whole run
    localparam int LIMIT_CYCLES = 500000;
    // quiet cycles after the last force
    localparam int TAIL_CYCLES  = 60;
    // cycles to let pass before touching the registers
    localparam int SETTLE       = 4;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] proxy;
        logic [AXES-1:0][COORD_W-1:0] target;
    } t_positions;

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic signed [COORD_W-1:0]  i_proxy_x   = '0;
    logic signed [COORD_W-1:0]  i_proxy_y   = '0;
    logic signed [COORD_W-1:0]  i_proxy_z   = '0;
    logic signed [COORD_W-1:0]  i_object_x  = '0;
    logic signed [COORD_W-1:0]  i_object_y  = '0;
    logic signed [COORD_W-1:0]  i_object_z  = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [COORD_W-1:0]  o_force_x;
    logic signed [COORD_W-1:0]  o_force_y;
    logic signed [COORD_W-1:0]  o_force_z;
    logic                       o_spring_region;
    logic                       o_limited;
    logic                       o_enabled;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx   = '0;
    logic [CFG_W-1:0]           i_cfg_data  = '0;

    // predictor copy of the registers and the warm-up counter
    logic [GAIN_W-1:0]          gain_reg    = GAIN_RST;
    logic [RAD_W-1:0]           radius_reg  = RAD_RST;
    logic [MAXF_W-1:0]          maxf_reg    = MAXF_RST;
    logic [WARM_W-1:0]          warm_reg    = WARM_RST;
    logic [TICK_W-1:0]          tick_reg    = '0;

    t_positions                 positions_q [$];
    t_result                    forces_q [$];

    int                         n_sent      = 0;
    int                         n_taken     = 0;
    int                         n_errors    = 0;
    int                         n_cycles    = 0;
    int                         n_writes    = 0;
    int                         n_spring    = 0;
    int                         n_inverse   = 0;
    int                         n_clamped   = 0;
    int                         n_live      = 0;
    int                         idle_pct    = 0;
    int                         stall_pct   = 0;

    haptic_attraction_force DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_proxy_x       (i_proxy_x),
        .i_proxy_y       (i_proxy_y),
        .i_proxy_z       (i_proxy_z),
        .i_object_x      (i_object_x),
        .i_object_y      (i_object_y),
        .i_object_z      (i_object_z),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_force_x       (o_force_x),
        .o_force_y       (o_force_y),
        .o_force_z       (o_force_z),
        .o_spring_region (o_spring_region),
        .o_limited       (o_limited),
        .o_enabled       (o_enabled),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Work out the clamped force for one pair of positions and advance the warm-up count
    function automatic t_result attraction_force(t_positions pos);
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        mag [AXES];
        logic [AXES-1:0]         neg;
        logic [D2_W-1:0]         d2;
        logic [D2_W-1:0]         den;
        logic [RSQ_W-1:0]        rsq;
        logic [127:0]            num;
        logic [127:0]            quo;
        logic [MAXF_W-1:0]       mag_f;
        logic [TICK_W:0]         nxt;
        logic                    live;
        t_result                 res;
        d2 = '0;
        for (int a = 0; a < AXES; a++) begin
            diff = $signed({pos.target[a][COORD_W-1], pos.target[a]})
                 - $signed({pos.proxy[a][COORD_W-1], pos.proxy[a]});
            neg[a] = diff[COORD_W];
            mag[a] = neg[a] ? -diff : diff;
            d2 = d2 + D2_W'(mag[a]) * D2_W'(mag[a]);
        end
        rsq = RSQ_W'(radius_reg) * RSQ_W'(radius_reg);
        res.spring = d2 < D2_W'({rsq, 2'b00});
        den = res.spring ? D2_W'(rsq) : d2;

        // saturate the tick count one past the warm-up length
        nxt = {1'b0, tick_reg} + 1'b1;
        live = nxt > (TICK_W + 1)'(warm_reg);
        tick_reg = live ? TICK_W'(warm_reg) + 1'b1 : nxt[TICK_W-1:0];
        res.enabled = live;
        res.limited = 1'b0;

        for (int a = 0; a < AXES; a++) begin
            quo = '0;
            if (den != '0) begin
                num = (128'(gain_reg) * 128'(mag[a])) << (res.spring ? SHIFT_SPR : SHIFT_INV);
                quo = num / 128'(den);
            end
            if (quo > 128'(maxf_reg)) begin
                mag_f = maxf_reg;
                if (live)
                    res.limited = 1'b1;
            end else begin
                mag_f = quo[MAXF_W-1:0];
            end
            if (!live)
                res.force_v[a] = '0;
            else if (neg[a])
                res.force_v[a] = COORD_W'(0) - COORD_W'(mag_f);
            else
                res.force_v[a] = COORD_W'(mag_f);
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
        if (got !== want) begin
            n_errors++;
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endtask

    // Drive the position channel and the force stall from the falling edge
    always @(negedge i_clk) begin
        t_positions pos;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            // hold a transfer that has not been taken yet
            if (!(i_in_valid && n_taken != n_sent)) begin
                if (positions_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    pos = positions_q.pop_front();
                    i_proxy_x  <= pos.proxy[0];
                    i_proxy_y  <= pos.proxy[1];
                    i_proxy_z  <= pos.proxy[2];
                    i_object_x <= pos.target[0];
                    i_object_y <= pos.target[1];
                    i_object_z <= pos.target[2];
                    n_sent++;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Mirror register writes, predict on each position transfer, check each force transfer
    always @(posedge i_clk) begin
        t_positions pos;
        t_result    want;
        if (!i_rst_n) begin
            gain_reg   = GAIN_RST;
            radius_reg = RAD_RST;
            maxf_reg   = MAXF_RST;
            warm_reg   = WARM_RST;
            tick_reg   = '0;
        end else begin
            if (i_cfg_we) begin
                n_writes++;
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_GAIN:   gain_reg   = i_cfg_data[GAIN_W-1:0];
                    CFG_RADIUS: radius_reg = i_cfg_data[RAD_W-1:0];
                    CFG_MAXF:   maxf_reg   = i_cfg_data[MAXF_W-1:0];
                    CFG_WARM:   warm_reg   = i_cfg_data[WARM_W-1:0];
                    default:    ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                pos.proxy  = {i_proxy_z, i_proxy_y, i_proxy_x};
                pos.target = {i_object_z, i_object_y, i_object_x};
                forces_q.insert(forces_q.size(), attraction_force(pos));
                n_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (forces_q.size() == 0) begin
                    n_errors++;
                    $error("force transfer with none pending: force_x %0d", o_force_x);
                end else begin
                    want = forces_q.pop_front();
                    check_field("force_x", want.force_v[0], o_force_x);
                    check_field("force_y", want.force_v[1], o_force_y);
                    check_field("force_z", want.force_v[2], o_force_z);
                    check_field("spring_region", COORD_W'(want.spring), COORD_W'(o_spring_region));
                    check_field("limited", COORD_W'(want.limited), COORD_W'(o_limited));
                    check_field("enabled", COORD_W'(want.enabled), COORD_W'(o_enabled));
                    if (want.spring)
                        n_spring++;
                    else
                        n_inverse++;
                    if (want.limited)
                        n_clamped++;
                    if (want.enabled)
                        n_live++;
                end
            end
        end
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Queue one item: proxy position and an offset to the target, wrapping per axis
    function automatic void queue_move(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                       logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        t_positions pos;
        pos.proxy  = {pz, py, px};
        pos.target = {pz + dz, py + dy, px + dx};
        positions_q.insert(positions_q.size(), pos);
    endfunction

    // Random offset: full noise, near the core, a random power-of-two scale, or none
    function automatic logic [31:0] rand_offset(int kind);
        longint lim;
        longint v;
        int     k;
        case (kind)
            0: v = $urandom;
            1: begin
                lim = 3 * longint'(radius_reg);
                if (lim > (longint'(1) << 30))
                    lim = longint'(1) << 30;
                v = longint'($urandom_range(0, 32'(2 * lim))) - lim;
            end
            2: begin
                k = $urandom_range(0, 30);
                v = $urandom & ((32'd1 << k) - 32'd1);
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = 0;
        endcase
        return v[31:0];
    endfunction

    function automatic logic [31:0] rand_proxy(int kind);
        logic [31:0] r;
        r = $urandom;
        return (kind == 0) ? r : {{2{r[29]}}, r[29:0]};
    endfunction

    function automatic void queue_random();
        int pick;
        int kind;
        pick = $urandom_range(99);
        kind = (pick < 15) ? 0 : (pick < 50) ? 1 : (pick < 90) ? 2 : 3;
        queue_move(rand_proxy(kind), rand_proxy(kind), rand_proxy(kind),
                   rand_offset(kind), rand_offset(kind), rand_offset(kind));
    endfunction

    // Random value with a random bit length, so small and huge settings both occur
    function automatic logic [31:0] rand_scaled(int w);
        int k;
        k = $urandom_range(0, w);
        return (k == 0) ? 32'd0 : ($urandom >> (32 - k));
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Wait until every queued item has been taken and every force has come back
    task automatic wait_drained();
        while (positions_q.size() != 0 || n_sent != n_taken || forces_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 11; stall_pct = 11; end
        endcase
    endtask

    initial begin
        logic [31:0] r2;
        logic [31:0] rdata;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: still warming up, so only the region flag shows
        set_idling(0);
        queue_move(32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0);
        queue_move(32'd0, 32'd0, 32'd0, 32'h0100_0000, 32'd0, 32'd0);
        queue_move(32'h8000_0000, 32'd7, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        wait_drained();

        // warm-up off, default law parameters: core edge, signs, extremes, zero distance
        write_reg(CFG_WARM, 31'd0);
        r2 = 32'(RAD_RST) * 2;
        queue_move(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_move(32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 32'd0, 32'd0, 32'd0);
        queue_move(32'd100, 32'd0, 32'd0, r2 - 1, 32'd0, 32'd0);
        queue_move(32'd100, 32'd0, 32'd0, r2, 32'd0, 32'd0);
        queue_move(32'd0, 32'hFFFF_0000, 32'd0, 32'd0, -(r2 - 1), 32'd0);
        queue_move(32'd0, 32'd0, 32'h0003_0000, 32'd0, 32'd0, -r2);
        queue_move(32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1);
        queue_move(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        queue_move(32'd0, 32'd0, 32'd0, 32'h0064_0000, 32'hFF9C_0000, 32'd0);
        wait_drained();

        // largest gain, radius and limit
        set_idling(3);
        write_reg(CFG_GAIN, 31'h7FFF_FFFF);
        write_reg(CFG_RADIUS, 31'h00FF_FFFF);
        write_reg(CFG_MAXF, 31'h7FFF_FFFF);
        r2 = 32'h00FF_FFFF * 2;
        queue_move(32'h8000_0000, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_move(32'd0, 32'd0, 32'd0, r2 - 1, 32'd0, 32'd0);
        queue_move(32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
        wait_drained();

        // zero radius: the inverse law everywhere, zero distance gives no force
        write_reg(CFG_RADIUS, 31'd0);
        write_reg(CFG_GAIN, 31'(GAIN_RST));
        queue_move(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_move(32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
        queue_move(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'd0);
        wait_drained();

        // longest warm-up: forces drop back to zero
        write_reg(CFG_WARM, 31'hFFFF);
        write_reg(CFG_RADIUS, 31'(RAD_RST));
        queue_random();
        queue_random();
        wait_drained();

        // random phases with fresh settings and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            set_idling(ph);
            rdata = (ph % 3 == 0) ? $urandom : 32'd1 + rand_scaled(22);
            write_reg(CFG_GAIN, (ph == 2) ? 31'd0 : (ph == 3) ? 31'h7FFF_FFFF
                                          : 31'(rand_scaled(31)));
            write_reg(CFG_RADIUS, (ph == 2) ? 31'd1 : 31'(rdata));
            write_reg(CFG_MAXF, (ph == 1) ? 31'd0 : (ph == 3) ? 31'h7FFF_FFFF
                                          : 31'(rand_scaled(31)));
            write_reg(CFG_WARM, (ph % 3 == 1) ? 31'($urandom_range(0, 3))
                                              : 31'($urandom_range(0, 60)));
            for (int n = 0; n < 48; n++) begin
                queue_random();
                // let the pipeline run dry once per phase
                if (n == 23)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("%0d position transfers over %0d register writes: %0d spring, %0d inverse",
                 n_taken, n_writes, n_spring, n_inverse);
        $display("%0d forces driven after warm-up, %0d of them clamped", n_live, n_clamped);
        if (n_errors == 0 && forces_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
src/haf_pkg.sv
src/haf_sequencer.sv
src/haf_div_lane.sv
src/haf_datapath.sv
src/haptic_attraction_force.sv
test/tb.sv
